// ===== rtl/mcc_pkg.sv =====
// Shared types, character codes and Morse tables for the Morse codec.
`default_nettype none
package mcc_pkg;

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;

   localparam int unsigned NUM_LETTERS = 26;
   localparam logic [2:0] MAX_SYMBOLS  = 3'd4;
   localparam logic [2:0] TOO_LONG     = 3'd5;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic REG_MODE = 1'b0;

   typedef struct packed {
      logic       decode;
      logic [4:0] idx;
   } job_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } match_type;

   function automatic logic [2:0] code_len(input logic [4:0] idx);
      logic [2:0] len;
      case (idx)
         5'd0:  len = 3'd2;  5'd1:  len = 3'd4;  5'd2:  len = 3'd4;
         5'd3:  len = 3'd3;  5'd4:  len = 3'd1;  5'd5:  len = 3'd4;
         5'd6:  len = 3'd3;  5'd7:  len = 3'd4;  5'd8:  len = 3'd2;
         5'd9:  len = 3'd4;  5'd10: len = 3'd3;  5'd11: len = 3'd4;
         5'd12: len = 3'd2;  5'd13: len = 3'd2;  5'd14: len = 3'd3;
         5'd15: len = 3'd4;  5'd16: len = 3'd4;  5'd17: len = 3'd3;
         5'd18: len = 3'd3;  5'd19: len = 3'd1;  5'd20: len = 3'd3;
         5'd21: len = 3'd4;  5'd22: len = 3'd3;  5'd23: len = 3'd4;
         5'd24: len = 3'd4;  5'd25: len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // bit i is symbol i, 1 = dash
   function automatic logic [3:0] code_pat(input logic [4:0] idx);
      logic [3:0] pat;
      case (idx)
         5'd0:  pat = 4'd2;   5'd1:  pat = 4'd1;   5'd2:  pat = 4'd5;
         5'd3:  pat = 4'd1;   5'd4:  pat = 4'd0;   5'd5:  pat = 4'd4;
         5'd6:  pat = 4'd3;   5'd7:  pat = 4'd0;   5'd8:  pat = 4'd0;
         5'd9:  pat = 4'd14;  5'd10: pat = 4'd5;   5'd11: pat = 4'd2;
         5'd12: pat = 4'd3;   5'd13: pat = 4'd1;   5'd14: pat = 4'd7;
         5'd15: pat = 4'd6;   5'd16: pat = 4'd11;  5'd17: pat = 4'd2;
         5'd18: pat = 4'd0;   5'd19: pat = 4'd1;   5'd20: pat = 4'd4;
         5'd21: pat = 4'd8;   5'd22: pat = 4'd6;   5'd23: pat = 4'd9;
         5'd24: pat = 4'd13;  5'd25: pat = 4'd3;
         default: pat = 4'd0;
      endcase
      return pat;
   endfunction

   function automatic match_type find_letter(input logic [2:0] len, input logic [3:0] pat);
      match_type m;
      m = '0;
      for (int b = NUM_LETTERS - 1; b >= 0; b--) begin
         if (code_len(5'(b)) == len && code_pat(5'(b)) == pat) begin
            m.hit = 1'b1;
            m.idx = 5'(b);
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mcc_front.sv =====
// Front end: classifies each request and tracks the open decode token.
`default_nettype none
module mcc_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            mode,
   input  wire logic            token_clear,
   input  wire logic            accept,
   input  wire logic [7:0]      in_char,
   input  wire logic            end_of_line,
   output logic                 job_wr,
   output mcc_pkg::job_type     job
);
   import mcc_pkg::*;

   logic [3:0] tok_bits_ff, tok_bits_in;
   logic [2:0] tok_len_ff,  tok_len_in;
   logic       tok_bad_ff,  tok_bad_in;

   logic       is_sep, is_sym, is_upper, is_lower, do_close;
   logic [3:0] add_bits;
   logic [2:0] add_len;
   logic       add_bad;
   logic [7:0] up_char;
   match_type  m;

   always_comb begin
      is_sep = in_char == CH_SPACE || in_char == CH_TAB || in_char == CH_LF ||
               in_char == CH_VT || in_char == CH_FF || in_char == CH_CR;
      is_sym = in_char == CH_DOT || in_char == CH_DASH;
      is_upper = in_char >= CH_UP_A && in_char <= CH_UP_Z;
      is_lower = in_char >= CH_LO_A && in_char <= CH_LO_Z;
      up_char  = is_lower ? (in_char - (CH_LO_A - CH_UP_A)) : in_char;

      add_bits = tok_bits_ff;
      add_len  = tok_len_ff;
      add_bad  = tok_bad_ff;
      if (!is_sep) begin
         if (is_sym) begin
            if (tok_len_ff < MAX_SYMBOLS) begin
               if (in_char == CH_DASH) begin
                  add_bits[tok_len_ff[1:0]] = 1'b1;
               end
               add_len = tok_len_ff + 3'd1;
            end else begin
               add_len = TOO_LONG;
            end
         end else begin
            add_bad = 1'b1;
         end
      end

      do_close = is_sep || end_of_line;
      m = find_letter(add_len, add_bits);

      job_wr     = 1'b0;
      job.decode = mode;
      job.idx    = '0;
      tok_bits_in = tok_bits_ff;
      tok_len_in  = tok_len_ff;
      tok_bad_in  = tok_bad_ff;

      if (accept) begin
         if (mode == MODE_ENCODE) begin
            job_wr  = is_upper || is_lower;
            job.idx = 5'(up_char - CH_UP_A);
            tok_bits_in = '0;
            tok_len_in  = '0;
            tok_bad_in  = 1'b0;
         end else if (do_close) begin
            job_wr  = !add_bad && add_len != 3'd0 && add_len <= MAX_SYMBOLS && m.hit;
            job.idx = m.idx;
            tok_bits_in = '0;
            tok_len_in  = '0;
            tok_bad_in  = 1'b0;
         end else begin
            tok_bits_in = add_bits;
            tok_len_in  = add_len;
            tok_bad_in  = add_bad;
         end
      end

      if (token_clear) begin
         tok_bits_in = '0;
         tok_len_in  = '0;
         tok_bad_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_bits_ff <= '0;
         tok_len_ff  <= '0;
         tok_bad_ff  <= 1'b0;
      end else begin
         tok_bits_ff <= tok_bits_in;
         tok_len_ff  <= tok_len_in;
         tok_bad_ff  <= tok_bad_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mcc_queue.sv =====
// Short job queue between front end and back end.
`default_nettype none
module mcc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr,
   input  wire mcc_pkg::job_type wdata,
   output logic                 full,
   input  wire logic            rd,
   output mcc_pkg::job_type     rdata,
   output logic                 empty
);
   import mcc_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   job_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;
   logic            do_wr, do_rd;

   always_comb begin
      full  = count_ff == CW'(DEPTH);
      empty = count_ff == '0;
      rdata = slot_ff[rd_ptr_ff];
      do_wr = wr && !full;
      do_rd = rd && !empty;
      wr_ptr_in = do_wr ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = do_rd ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_wr) - CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mcc_back.sv =====
// Back end: expands queued jobs into output characters, one per cycle unless the output is stalled.
`default_nettype none
module mcc_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_empty,
   input  wire mcc_pkg::job_type q_data,
   output logic                 q_rd,
   output logic                 out_valid,
   output logic [7:0]           out_char,
   output logic                 out_last,
   input  wire logic            out_pop
);
   import mcc_pkg::*;

   job_type    job_ff,  job_in;
   logic       busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff,  out_char_in;
   logic       out_last_ff,  out_last_in;

   logic       can_adv, final_step;
   logic [2:0] len;
   logic [3:0] pat;
   logic [7:0] sym_char;

   always_comb begin
      len = code_len(job_ff.idx);
      pat = code_pat(job_ff.idx);
      can_adv = !out_valid_ff || out_pop;
      if (job_ff.decode) begin
         final_step = step_ff == 3'd1;
         sym_char   = (step_ff == 3'd0) ? (CH_UP_A + {3'b000, job_ff.idx}) : CH_SPACE;
      end else begin
         final_step = step_ff == len;
         if (step_ff < len) begin
            sym_char = pat[step_ff[1:0]] ? CH_DASH : CH_DOT;
         end else begin
            sym_char = CH_SPACE;
         end
      end
      q_rd = !q_empty && (!busy_ff || (can_adv && final_step));

      job_in       = job_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (can_adv) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            out_char_in = sym_char;
            out_last_in = final_step;
            if (final_step) begin
               busy_in = 1'b0;
               step_in = '0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
      end
      if (q_rd) begin
         busy_in = 1'b1;
         job_in  = q_data;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> step_ff == 3'd0)
      else $error("step counter not zero while idle");

   a_decode_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && job_ff.decode |-> step_ff <= 3'd1)
      else $error("decode job ran past its space");

   a_encode_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !job_ff.decode |-> step_ff <= code_len(job_ff.idx))
      else $error("encode job ran past its space");

   a_take_on_finish: assert property (@(posedge clock) disable iff (reset)
      q_rd && busy_ff |-> can_adv && final_step)
      else $error("job loaded over an unfinished one");

endmodule
`default_nettype wire

// ===== rtl/morse_code_codec_core.sv =====
// Top level of the Morse codec: job queue, result register and mode register.
//
// Requests enter on push/full: one ASCII byte (req_in_char) and a line-end
// flag (req_end_of_line), taken at an edge with push high and full low.
// Results leave on empty/pop: rsp_out_char is '.', '-', ' ' or a capital
// letter, rsp_last marks the final result of a request. A result is taken
// at an edge with pop high and empty low.
// Mode (register 0, byte address 0): 0 encodes letters to Morse, 1 decodes
// Morse tokens to letters. Writing it clears any open token.
// A taken request's job is written to the job queue, then loaded into the
// back end, whose output register holds the first result. Results stream
// one per cycle while pop keeps up, so an encoded letter gives 2 to 5
// results and a decoded letter 2; the single-character output register sets
// that rate. Requests flow back to back while full is low into a job queue
// of QUEUE_DEPTH entries; full rises when that queue fills.
// Reset clears the job queue, the result register and the open token and sets encode mode.
// A stalled receiver holds the current result; requests keep being taken
// until the job queue fills.
`default_nettype none
module morse_code_codec_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_char,
   input  wire logic        req_end_of_line,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import mcc_pkg::*;

   logic    mode_ff, mode_in;
   logic    cfg_wr, accept, job_wr, q_empty, q_rd, out_valid;
   job_type job, q_data;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && paddr[2] == REG_MODE;
   assign mode_in = cfg_wr ? pwdata[0] : mode_ff;
   assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign accept = push && !full;

   mcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .token_clear (cfg_wr),
      .accept      (accept),
      .in_char     (req_in_char),
      .end_of_line (req_end_of_line),
      .job_wr      (job_wr),
      .job         (job)
   );

   mcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (job_wr),
      .wdata (job),
      .full  (full),
      .rd    (q_rd),
      .rdata (q_data),
      .empty (q_empty)
   );

   mcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_rd      (q_rd),
      .out_valid (out_valid),
      .out_char  (rsp_out_char),
      .out_last  (rsp_last),
      .out_pop   (pop)
   );

   assign empty = !out_valid;

endmodule
`default_nettype wire
